### design/lge_pkg.sv
// Shared types and constants for the life generation engine.
// Holds the function codes, cell state codes and neighbour count type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

    // Field widths fixed by the item format
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 4;
    localparam int STATE_W = 2;

    // Function codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

    // Cell state codes reported in cell_state
    localparam logic [STATE_W-1:0] CELL_DEAD  = 2'd0;
    localparam logic [STATE_W-1:0] CELL_ALIVE = 2'd1;
    localparam logic [STATE_W-1:0] CELL_WALL  = 2'd2;

    // Live neighbour count of one cell, zero to eight
    typedef logic [3:0] nbr_count_t;

    // B3/S23 rule thresholds
    localparam nbr_count_t BIRTH_COUNT   = 4'd3;
    localparam nbr_count_t SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

### design/life_generation_engine.sv
// Life generation engine: B3/S23 grid with a dead wall ring, two row banks in one memory.
// Write/read item: read the row, modify and write back the bit, then hold the result; advance: a row
// sweep of the memory read port (one row per cycle), then the same row read. One item at a time.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous; afterwards a clearing pass zeroes both banks, with in_ready low throughout.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_engine #(
    parameter int GRID_SIDE = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [lge_pkg::FUNC_W-1:0]   func,
    input  wire logic [lge_pkg::COORD_W-1:0]  row,
    input  wire logic [lge_pkg::COORD_W-1:0]  col,
    input  wire logic                         alive,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [lge_pkg::STATE_W-1:0]  cell_state,
    output logic                              generation_done
);

    localparam int SW = $clog2(GRID_SIDE);
    localparam int AW = SW + 1;
    localparam int CW = $clog2(GRID_SIDE + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ADV   = 6'b000100,
        S_ROW   = 6'b001000,
        S_MOD   = 6'b010000,
        S_DONE  = 6'b100000
    } fsm_state_t;

    fsm_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] adv_cnt_reg, adv_cnt_next;
    logic          active_reg, active_next;
    logic          out_valid_reg, out_valid_next;

    logic [lge_pkg::FUNC_W-1:0]  func_reg;
    logic [lge_pkg::COORD_W-1:0] row_reg;
    logic [lge_pkg::COORD_W-1:0] col_reg;
    logic                        alive_reg;
    logic                        wall_reg;
    logic [GRID_SIDE-1:0]        up_reg;
    logic [GRID_SIDE-1:0]        cen_reg;
    logic [lge_pkg::STATE_W-1:0] res_state_reg, res_state_next;
    logic                        res_done_reg, res_done_next;
    logic [lge_pkg::STATE_W-1:0] out_state_reg;
    logic                        out_done_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [GRID_SIDE-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [GRID_SIDE-1:0] mem_rdata;
    logic [GRID_SIDE-1:0] rule_row;

    logic                 in_xfer;
    logic                 in_wall;
    logic [SW-1:0]        row_idx;
    logic [SW-1:0]        col_idx;
    logic [CW-1:0]        adv_wr_row;
    logic                 slot_free;

    // Row store holding both banks: bank select is the top address bit
    lge_row_mem #(
        .WIDTH  (GRID_SIDE),
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next row from the sliding three-row window
    lge_row_rule #(
        .GRID_SIDE (GRID_SIDE)
    ) u_rule (
        .up_row   (up_reg),
        .mid_row  (cen_reg),
        .dn_row   (mem_rdata),
        .next_row (rule_row)
    );

    // Input side decode
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign in_wall   = (row == '0) || (col == '0) ||
                       (32'(row) >= 32'(GRID_SIDE - 1)) ||
                       (32'(col) >= 32'(GRID_SIDE - 1));
    assign row_idx    = SW'(row_reg);
    assign col_idx    = SW'(col_reg);
    assign adv_wr_row = adv_cnt_reg - CW'(2);
    assign slot_free  = !out_valid_reg || out_ready;

    // Sequencer and memory port control
    always_comb
    begin
        logic [GRID_SIDE-1:0] mod_row;
        logic                 cur_bit;
        logic                 new_bit;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        adv_cnt_next   = adv_cnt_reg;
        active_next    = active_reg;
        res_state_next = res_state_reg;
        res_done_next  = res_done_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        mod_row        = mem_rdata;
        cur_bit        = mem_rdata[col_idx];
        new_bit        = cur_bit;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    adv_cnt_next = '0;
                    state_next   = (func == lge_pkg::FUNC_ADVANCE) ? S_ADV : S_ROW;
                end
            end
            S_ADV:
            begin
                // Read source row cnt; write destination row cnt-2
                mem_raddr = {active_reg, adv_cnt_reg[SW-1:0]};
                if (adv_cnt_reg >= CW'(3))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {~active_reg, adv_wr_row[SW-1:0]};
                    mem_wdata = rule_row;
                end
                adv_cnt_next = adv_cnt_reg + CW'(1);
                if (adv_cnt_reg == CW'(GRID_SIDE))
                begin
                    active_next = ~active_reg;
                    state_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                mem_raddr  = {active_reg, row_idx};
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // Modify the addressed bit and write the row back
                if ((func_reg == lge_pkg::FUNC_WRITE) && !wall_reg)
                begin
                    new_bit          = alive_reg;
                    mod_row[col_idx] = alive_reg;
                    mem_we           = 1'b1;
                    mem_waddr        = {active_reg, row_idx};
                    mem_wdata        = mod_row;
                end
                if (wall_reg)
                begin
                    res_state_next = lge_pkg::CELL_WALL;
                end
                else
                begin
                    res_state_next = new_bit ? lge_pkg::CELL_ALIVE : lge_pkg::CELL_DEAD;
                end
                res_done_next = (func_reg == lge_pkg::FUNC_ADVANCE);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on completion, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            adv_cnt_reg   <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            adv_cnt_reg   <= adv_cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: latched item, row window, result and output
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= func;
            row_reg   <= row;
            col_reg   <= col;
            alive_reg <= alive;
            wall_reg  <= in_wall;
        end
        if (state_reg == S_ADV)
        begin
            up_reg  <= cen_reg;
            cen_reg <= mem_rdata;
        end
        res_state_reg <= res_state_next;
        res_done_reg  <= res_done_next;
        if ((state_reg == S_DONE) && slot_free)
        begin
            out_state_reg <= res_state_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cell_state      = out_state_reg;
    assign generation_done = out_done_reg;

    // During a sweep the source and destination banks never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_ADV)) |-> (mem_waddr[AW-1] != mem_raddr[AW-1]))
        else $error("advance writes into the bank it reads");

    // The active bank flips only at the end of a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != $past(active_reg)) |-> ($past(state_reg) == S_ADV))
        else $error("active bank changed outside an advance");

    // An advance result is read back in S_ROW then S_MOD, directly after the sweep ends
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOD) && (func_reg == lge_pkg::FUNC_ADVANCE))
            |-> ($past(state_reg, 2) == S_ADV))
        else $error("advance result read without a completed sweep");

    // A wall cell is never written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_MOD)) |-> !wall_reg)
        else $error("write back to a wall cell");

    // A finished result waits while the output slot is full
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result left while the output register was full");

endmodule

`default_nettype wire

### design/lge_row_mem.sv
// Row store for the life generation engine: one write port, one read port.
// Each entry holds one grid row; read data is registered.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lge_row_mem #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 5
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one row, read one row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/lge_row_rule.sv
// Next-generation logic for one grid row under the B3/S23 rule.
// Takes the rows above, at and below, and forces the wall columns dead.
// Depends on lge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lge_row_rule #(
    parameter int GRID_SIDE = 16
) (
    input  wire logic [GRID_SIDE-1:0] up_row,
    input  wire logic [GRID_SIDE-1:0] mid_row,
    input  wire logic [GRID_SIDE-1:0] dn_row,
    output logic      [GRID_SIDE-1:0] next_row
);

    // One lane per column; wall columns never live
    for (genvar j = 0; j < GRID_SIDE; j++)
    begin : g_lane
        if (j == 0 || j == GRID_SIDE - 1)
        begin : g_wall
            assign next_row[j] = 1'b0;
        end
        else
        begin : g_cell
            lge_pkg::nbr_count_t nbr;

            // Count the eight neighbours; wall cells are stored dead
            assign nbr = lge_pkg::nbr_count_t'(up_row[j-1]) +
                         lge_pkg::nbr_count_t'(up_row[j]) +
                         lge_pkg::nbr_count_t'(up_row[j+1]) +
                         lge_pkg::nbr_count_t'(mid_row[j-1]) +
                         lge_pkg::nbr_count_t'(mid_row[j+1]) +
                         lge_pkg::nbr_count_t'(dn_row[j-1]) +
                         lge_pkg::nbr_count_t'(dn_row[j]) +
                         lge_pkg::nbr_count_t'(dn_row[j+1]);

            // Birth on three, survival on two or three
            assign next_row[j] = (nbr == lge_pkg::BIRTH_COUNT) ||
                                 ((nbr == lge_pkg::SURVIVE_COUNT) && mid_row[j]);
        end
    end

endmodule

`default_nettype wire

### verif/tb_life_generation_engine.sv
// Self-checking testbench for life_generation_engine: cell writes, reads and B3/S23 generations.
// Keeps its own copy of the grid, predicts each result on input transfer, checks it on output.
// Depends on lge_pkg and the life_generation_engine RTL.
`timescale 1ns / 1ps

module tb_life_generation_engine;

    localparam int GRID_SIDE = 16;
    localparam int CLK_HALF  = 4;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_CMDS = 470;

    typedef logic [lge_pkg::FUNC_W-1:0] func_code_t;

    // Unused function code, answered like a read
    localparam func_code_t FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [lge_pkg::FUNC_W-1:0]  func;
        logic [lge_pkg::COORD_W-1:0] row;
        logic [lge_pkg::COORD_W-1:0] col;
        logic                        alive;
    } cell_cmd_t;

    typedef struct packed {
        logic [lge_pkg::STATE_W-1:0] state;
        logic                        done;
    } cell_answer_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [lge_pkg::FUNC_W-1:0]   func = '0;
    logic [lge_pkg::COORD_W-1:0]  row = '0;
    logic [lge_pkg::COORD_W-1:0]  col = '0;
    logic                         alive = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [lge_pkg::STATE_W-1:0]  cell_state;
    logic                         generation_done;

    // Predicted grid, commands waiting to be sent and answers still owed
    bit           life_grid [GRID_SIDE][GRID_SIDE];
    cell_cmd_t    pending_cmds[$];
    cell_answer_t expected_answers[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    life_generation_engine #(
        .GRID_SIDE(GRID_SIDE)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .row             (row),
        .col             (col),
        .alive           (alive),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_state      (cell_state),
        .generation_done (generation_done)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic bit wall_cell(int r, int c);
        return r == 0 || c == 0 || r >= GRID_SIDE - 1 || c >= GRID_SIDE - 1;
    endfunction

    // Advance the predicted grid one generation under B3/S23
    function automatic void evolve_grid();
        bit nxt [GRID_SIDE][GRID_SIDE];
        int nbrs;
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            for (int c = 0; c < GRID_SIDE; c++)
            begin
                nxt[r][c] = 1'b0;
                if (!wall_cell(r, c))
                begin
                    nbrs = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if ((dr != 0 || dc != 0) && !wall_cell(r + dr, c + dc))
                                nbrs += int'(life_grid[r + dr][c + dc]);
                    nxt[r][c] = (nbrs == int'(lge_pkg::BIRTH_COUNT)) ||
                                (nbrs == int'(lge_pkg::SURVIVE_COUNT) && life_grid[r][c]);
                end
            end
        end
        life_grid = nxt;
    endfunction

    function automatic cell_answer_t predict_cell_answer(cell_cmd_t cmd);
        cell_answer_t ans;
        bit wall;
        wall = wall_cell(int'(cmd.row), int'(cmd.col));
        ans.done = 1'b0;
        if (cmd.func == lge_pkg::FUNC_WRITE)
        begin
            if (!wall)
                life_grid[cmd.row][cmd.col] = cmd.alive;
        end
        else if (cmd.func == lge_pkg::FUNC_ADVANCE)
        begin
            evolve_grid();
            ans.done = 1'b1;
        end
        if (wall)
            ans.state = lge_pkg::CELL_WALL;
        else
            ans.state = life_grid[cmd.row][cmd.col] ? lge_pkg::CELL_ALIVE : lge_pkg::CELL_DEAD;
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    function automatic void push_cmd(func_code_t f, int r, int c, bit a);
        cell_cmd_t cmd;
        cmd.func  = f;
        cmd.row   = r[lge_pkg::COORD_W-1:0];
        cmd.col   = c[lge_pkg::COORD_W-1:0];
        cmd.alive = a;
        pending_cmds.push_back(cmd);
    endfunction

    // Seed a random patch, then run a few generations with reads in between
    function automatic int queue_colony();
        int r0, c0, h, w, gens, added;
        added = 0;
        h  = $urandom_range(2, 5);
        w  = $urandom_range(2, 5);
        r0 = $urandom_range(1, GRID_SIDE - 1 - h);
        c0 = $urandom_range(1, GRID_SIDE - 1 - w);
        for (int r = r0; r < r0 + h; r++)
            for (int c = c0; c < c0 + w; c++)
            begin
                push_cmd(lge_pkg::FUNC_WRITE, r, c, $urandom_range(99) < 45);
                added++;
            end
        gens = $urandom_range(2, 6);
        repeat (gens)
        begin
            push_cmd(lge_pkg::FUNC_ADVANCE, $urandom_range(r0 - 1, r0 + h),
                     $urandom_range(c0 - 1, c0 + w), 1'($urandom_range(1)));
            added++;
            repeat ($urandom_range(0, 2))
            begin
                push_cmd(lge_pkg::FUNC_READ, $urandom_range(r0 - 1, r0 + h),
                         $urandom_range(c0 - 1, c0 + w), 1'($urandom_range(1)));
                added++;
            end
        end
        return added;
    endfunction

    // Anything the fields allow, walls and the spare code included
    function automatic int queue_noise();
        int n;
        n = $urandom_range(3, 8);
        repeat (n)
            push_cmd(func_code_t'($urandom_range(3)), $urandom_range(15),
                     $urandom_range(15), 1'($urandom_range(1)));
        return n;
    endfunction

    // Driver: predict on transfer, load the next command when the slot frees
    always @(posedge clk)
    begin : drive_cmds
        cell_cmd_t cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cmd.func  = func;
                cmd.row   = row;
                cmd.col   = col;
                cmd.alive = alive;
                expected_answers.push_back(predict_cell_answer(cmd));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    func     <= cmd.func;
                    row      <= cmd.row;
                    col      <= cmd.col;
                    alive    <= cmd.alive;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, then decide the next ready
    always @(posedge clk)
    begin : watch_answers
        cell_answer_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("unexpected result, cell_state", int'(cell_state), 0);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (cell_state !== want.state)
                        report_mismatch("cell_state", int'(cell_state), int'(want.state));
                    if (generation_done !== want.done)
                        report_mismatch("generation_done", int'(generation_done),
                                        int'(want.done));
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left   <= LONG_HOLD;
                out_ready   <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus: directed checks, then four phases of random colonies and noise commands
    initial
    begin : stimulus
        int added;
        int send_pct [4] = '{0, 81, 0, 8};
        int recv_pct [4] = '{0, 0, 81, 8};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walls, spare code, interior corners and a blinker
        push_cmd(lge_pkg::FUNC_READ,    0,  0, 1'b0);
        push_cmd(lge_pkg::FUNC_READ,   15, 15, 1'b1);
        push_cmd(lge_pkg::FUNC_READ,    5,  5, 1'b0);
        push_cmd(lge_pkg::FUNC_WRITE,   0,  7, 1'b1);
        push_cmd(lge_pkg::FUNC_READ,    0,  7, 1'b0);
        push_cmd(lge_pkg::FUNC_WRITE,  15,  3, 1'b1);
        push_cmd(lge_pkg::FUNC_WRITE,   1,  1, 1'b1);
        push_cmd(lge_pkg::FUNC_WRITE,  14, 14, 1'b1);
        push_cmd(lge_pkg::FUNC_READ,   14, 14, 1'b0);
        push_cmd(FUNC_SPARE,            1,  1, 1'b0);
        push_cmd(lge_pkg::FUNC_WRITE,   7,  6, 1'b1);
        push_cmd(lge_pkg::FUNC_WRITE,   7,  7, 1'b1);
        push_cmd(lge_pkg::FUNC_WRITE,   7,  8, 1'b1);
        push_cmd(lge_pkg::FUNC_ADVANCE, 6,  7, 1'b0);
        push_cmd(lge_pkg::FUNC_READ,    7,  6, 1'b0);
        push_cmd(lge_pkg::FUNC_READ,    8,  7, 1'b1);
        push_cmd(lge_pkg::FUNC_ADVANCE, 7,  6, 1'b1);
        push_cmd(lge_pkg::FUNC_WRITE,   1,  1, 1'b0);
        push_cmd(lge_pkg::FUNC_READ,    1,  1, 1'b0);
        push_cmd(lge_pkg::FUNC_ADVANCE, 0,  0, 1'b0);
        push_cmd(lge_pkg::FUNC_ADVANCE, 15, 9, 1'b1);
        push_cmd(FUNC_SPARE,           15, 15, 1'b1);

        // Wait until every command is sent and every answer is back
        while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
            @(negedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            added = 0;
            while (added < PHASE_CMDS)
                added += ($urandom_range(99) < 80) ? queue_colony() : queue_noise();
            // Hold off the receiver while commands keep coming
            if (ph == 0)
            begin
                repeat (30) @(negedge clk);
                hold_requests++;
            end
            while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
                @(negedge clk);
        end

        repeat (GRID_SIDE + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
